@@ hdl/jlf_pkg.sv @@
// shared constants and types for the json line framer
// used by jlf_line_store and json_line_framer; no dependencies
package jlf_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 6;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BRACE = 8'h7B;

  typedef enum logic {OP_DATA = 1'b0, OP_DISCONNECT = 1'b1} jlf_op_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } jlf_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } jlf_rd_t;

endpackage

@@ hdl/json_line_framer.sv @@
// json line framer: bytes are accepted one per cycle while a line is gathered.
// a terminator that closes a line starting with a brace starts a replay; its
// reads pass the state register, store read register and output queue, then
// results leave one per cycle unless out_tready stalls, set by the single read
// port of the line store. input is held off while replay reads run. synchronous
// reset clears state, fill count, discard flag and output queue; the brace flag and line store are not cleared.
module json_line_framer
  import jlf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] line_byte, [13:8] line_length, [15:14] zero
  output logic        out_tlast   // last
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_REPLAY  = 2'b10
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } entry_t;

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_CAPACITY - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic              disc_r, disc_nxt;
  logic              brace_r, brace_nxt;
  logic [ADDR_W-1:0] rep_len_r, rep_len_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;

  // read in flight and its tag
  logic              pend_r;
  logic              pend_last_r;
  logic [LEN_W-1:0]  pend_len_r;

  // two-entry output queue
  entry_t            q_r [2];
  logic              q_wp_r, q_rp_r;
  logic [1:0]        q_occ_r;

  jlf_wr_t           wr;
  jlf_rd_t           rd;
  logic [BYTE_W-1:0] rd_data;

  logic              in_xfer, out_xfer, is_term, issue, issue_last;
  logic [2:0]        room_used;
  logic [BYTE_W-1:0] in_byte;

  jlf_line_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_byte   = in_tdata;
  assign in_tready = (state_r == ST_COLLECT);
  assign in_xfer   = in_tvalid & in_tready;
  assign is_term   = (in_byte == CH_LF) || (in_byte == CH_CR);

  assign out_tvalid = (q_occ_r != 2'd0);
  assign out_xfer   = out_tvalid & out_tready;
  assign out_tdata  = {2'b00, q_r[q_rp_r].len, q_r[q_rp_r].data};
  assign out_tlast  = q_r[q_rp_r].last;

  // slots taken once this cycle's output transfer leaves
  assign room_used  = 3'(q_occ_r) + 3'(pend_r) - 3'(out_xfer);
  assign issue      = (state_r == ST_REPLAY) && (room_used < 3'd2);
  assign issue_last = (rd_addr_r == ADDR_W'(rep_len_r - 1'b1));

  assign rd.en   = issue;
  assign rd.addr = rd_addr_r;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    disc_nxt    = disc_r;
    brace_nxt   = brace_r;
    rep_len_nxt = rep_len_r;
    rd_addr_nxt = rd_addr_r;
    wr.en       = 1'b0;
    wr.addr     = fill_r;
    wr.data     = in_byte;

    unique case (state_r)
      ST_COLLECT: begin
        if (in_xfer) begin
          if (in_tuser == OP_DISCONNECT) begin
            fill_nxt = '0;
            disc_nxt = 1'b0;
          end else if (is_term) begin
            if (!disc_r && (fill_r != '0) && brace_r) begin
              state_nxt   = ST_REPLAY;
              rep_len_nxt = fill_r;
              rd_addr_nxt = '0;
            end
            disc_nxt = 1'b0;
            fill_nxt = '0;
          end else if (!disc_r) begin
            if (fill_r < FILL_MAX) begin
              wr.en    = 1'b1;
              fill_nxt = fill_r + 1'b1;
              if (fill_r == '0) begin
                brace_nxt = (in_byte == CH_BRACE);
              end
            end else begin
              // overflow: drop the line and skip to the next terminator
              fill_nxt = '0;
              disc_nxt = 1'b1;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (issue) begin
          rd_addr_nxt = rd_addr_r + 1'b1;
          if (issue_last) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      fill_r  <= '0;
      disc_r  <= 1'b0;
      pend_r  <= 1'b0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_occ_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      disc_r  <= disc_nxt;
      pend_r  <= issue;
      if (pend_r) begin
        q_wp_r <= ~q_wp_r;
      end
      if (out_xfer) begin
        q_rp_r <= ~q_rp_r;
      end
      q_occ_r <= q_occ_r + 2'(pend_r) - 2'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    brace_r   <= brace_nxt;
    rep_len_r <= rep_len_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (issue) begin
      pend_last_r <= issue_last;
      pend_len_r  <= LEN_W'(rep_len_r);
    end
    if (pend_r) begin
      q_r[q_wp_r] <= '{data: rd_data, len: pend_len_r, last: pend_last_r};
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (3'(q_occ_r) + 3'(pend_r)) <= 3'd2)
    else $error("output queue overcommitted");

  a_pend_room: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (q_occ_r < 2'd2))
    else $error("read returned with no queue slot");

  a_disc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (fill_r == '0))
    else $error("partial line held while discarding");

  a_replay_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> (rep_len_r != '0))
    else $error("replay of an empty line");

  a_no_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> !wr.en)
    else $error("line store written during replay");
`endif

endmodule

@@ hdl/jlf_line_store.sv @@
// line store: one write port, one read port with registered read data
// depends on jlf_pkg for depth, widths and the port structs
module jlf_line_store
  import jlf_pkg::*;
(
  input  logic              clk,
  input  jlf_wr_t           wr,
  input  jlf_rd_t           rd,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [LINE_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
